// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CTOT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CTOT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ctot_pkg.sv =====
// Types, widths and pipeline stage numbers of the circle/triangle overlap test.
`default_nettype none

package ctot_pkg;

    localparam int CW   = 24;            // coordinate width
    localparam int TB   = 16;            // fraction bits of t
    localparam int DW   = 2 * (CW + 1) + 1;  // dot product width
    localparam int PXW  = CW + TB + 3;   // edge offset product width
    localparam int R2W  = 2 * (CW - 1);  // radius squared width

    // register stage numbers
    localparam int ST_IN   = 0;
    localparam int ST_DIFF = 1;
    localparam int ST_DOT  = 2;
    localparam int ST_DSET = 3;
    localparam int ST_DIV0 = 4;
    localparam int ST_TMUL = ST_DIV0 + TB;
    localparam int ST_PT   = ST_TMUL + 1;
    localparam int ST_DLT  = ST_PT + 1;
    localparam int ST_SQ   = ST_DLT + 1;
    localparam int ST_MIN  = ST_SQ + 1;
    localparam int ST_OUT  = ST_MIN + 1;
    localparam int NSTG    = ST_OUT + 1;

    typedef logic signed [CW-1:0]   coord_t;
    typedef logic        [CW-2:0]   radius_t;
    typedef logic signed [CW:0]     diff_t;
    typedef logic signed [2*CW+1:0] prod_t;
    typedef logic signed [DW-1:0]   dot_t;
    typedef logic        [DW-1:0]   mag_t;
    typedef logic signed [PXW-1:0]  pxw_t;
    typedef logic        [R2W-1:0]  rsq_t;
    typedef logic        [NSTG-1:0] stage_en_t;

    typedef struct packed {
        logic      zero;
        logic      full;
        mag_t      den;
        mag_t      rem;
        logic [TB-1:0] q;
    } div_t;

    typedef struct packed {
        diff_t  ex;
        diff_t  ey;
        coord_t ax;
        coord_t ay;
    } edge_carry_t;

    typedef struct packed {
        coord_t cx;
        coord_t cy;
        rsq_t   r2;
        logic   ctr_in;
    } side_t;

    function automatic div_t div_step(div_t d);
        div_t o;
        mag_t r2;
        o  = d;
        r2 = {d.rem[DW-2:0], 1'b0};
        if (r2 >= d.den) begin
            o.rem = r2 - d.den;
            o.q   = {d.q[TB-2:0], 1'b1};
        end else begin
            o.rem = r2;
            o.q   = {d.q[TB-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/circle_triangle_overlap_test.sv =====
// Top level of the pipelined circle/triangle overlap test.
//
//  channel  dir  handshake          word
//  s_       in   s_valid/s_ready    center, radius, three vertices
//  m_       out  m_valid/m_ready    overlaps, center_inside, nearest point
//
// One word per cycle sustained while m_ready holds high; 26 register stages.
// The t divider is a 16-stage restoring pipeline, one quotient bit per stage.
// Synchronous reset clears only the valid bits; payload registers are not reset.
// A stall holds each full stage; empty stages keep filling, so s_ready stays
// high while any bubble remains.
`default_nettype none

module circle_triangle_overlap_test import ctot_pkg::*; (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    output logic         s_ready,
    input  wire coord_t  s_center_x,
    input  wire coord_t  s_center_y,
    input  wire radius_t s_circle_radius,
    input  wire coord_t  s_vert0_x,
    input  wire coord_t  s_vert0_y,
    input  wire coord_t  s_vert1_x,
    input  wire coord_t  s_vert1_y,
    input  wire coord_t  s_vert2_x,
    input  wire coord_t  s_vert2_y,
    output logic         m_valid,
    input  wire          m_ready,
    output logic         m_overlaps,
    output logic         m_center_inside,
    output coord_t       m_nearest_x,
    output coord_t       m_nearest_y
);

    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   rdy;
    stage_en_t       ld;

    coord_t  cx_reg, cy_reg;
    radius_t r_reg;
    coord_t  vx_reg [3];
    coord_t  vy_reg [3];

    side_t   side_reg [ST_DIFF:ST_MIN];
    logic    neg [3];
    coord_t  qx [3];
    coord_t  qy [3];

    diff_t   dx_reg [3];
    diff_t   dy_reg [3];
    coord_t  qx_dlt_reg [3];
    coord_t  qy_dlt_reg [3];
    mag_t    d_reg [3];
    coord_t  qx_sq_reg [3];
    coord_t  qy_sq_reg [3];

    mag_t    best_reg, best_next;
    coord_t  nx_reg, nx_next, ny_reg, ny_next;
    logic    ovl_reg, ins_reg;
    coord_t  ox_reg, oy_reg;

    prod_t   sq_a [3];
    prod_t   sq_b [3];
    dot_t    sq_s [3];

    always_comb begin
        rdy[NSTG] = m_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        ld = rdy[NSTG-1:0];
    end

    assign s_ready = ld[ST_IN];
    assign m_valid = v_reg[ST_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[ST_IN]) begin
                v_reg[ST_IN] <= s_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (ld[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_IN]) begin
            cx_reg    <= s_center_x;
            cy_reg    <= s_center_y;
            r_reg     <= s_circle_radius;
            vx_reg[0] <= s_vert0_x;
            vy_reg[0] <= s_vert0_y;
            vx_reg[1] <= s_vert1_x;
            vy_reg[1] <= s_vert1_y;
            vx_reg[2] <= s_vert2_x;
            vy_reg[2] <= s_vert2_y;
        end
    end

    // center, radius squared and inside flag ride alongside the edge units
    always_ff @(posedge aclk) begin
        if (ld[ST_DIFF]) begin
            side_reg[ST_DIFF].cx     <= cx_reg;
            side_reg[ST_DIFF].cy     <= cy_reg;
            side_reg[ST_DIFF].r2     <= rsq_t'(r_reg) * rsq_t'(r_reg);
            side_reg[ST_DIFF].ctr_in <= 1'b0;
        end
        for (int k = ST_DOT; k <= ST_MIN; k++) begin
            if (ld[k]) begin
                if (k == ST_DSET) begin
                    side_reg[k].cx     <= side_reg[k-1].cx;
                    side_reg[k].cy     <= side_reg[k-1].cy;
                    side_reg[k].r2     <= side_reg[k-1].r2;
                    side_reg[k].ctr_in <= !(neg[0] || neg[1] || neg[2]);
                end else begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_edge
        localparam int J = (i + 1) % 3;
        ctot_edge u_edge (
            .aclk    (aclk),
            .ld      (ld),
            .ax      (vx_reg[i]),
            .ay      (vy_reg[i]),
            .bx      (vx_reg[J]),
            .by      (vy_reg[J]),
            .cx      (cx_reg),
            .cy      (cy_reg),
            .neg_out (neg[i]),
            .qx_out  (qx[i]),
            .qy_out  (qy[i])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_a[i] = dx_reg[i] * dx_reg[i];
            sq_b[i] = dy_reg[i] * dy_reg[i];
            sq_s[i] = dot_t'(sq_a[i]) + dot_t'(sq_b[i]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (ld[ST_DLT]) begin
                dx_reg[i]     <= diff_t'(qx[i]) - diff_t'(side_reg[ST_PT].cx);
                dy_reg[i]     <= diff_t'(qy[i]) - diff_t'(side_reg[ST_PT].cy);
                qx_dlt_reg[i] <= qx[i];
                qy_dlt_reg[i] <= qy[i];
            end
            if (ld[ST_SQ]) begin
                d_reg[i]     <= mag_t'(sq_s[i]);
                qx_sq_reg[i] <= qx_dlt_reg[i];
                qy_sq_reg[i] <= qy_dlt_reg[i];
            end
        end
    end

    // nearest of three, earlier edge wins a tie; the center itself when it lies inside
    always_comb begin
        best_next = d_reg[0];
        nx_next   = qx_sq_reg[0];
        ny_next   = qy_sq_reg[0];
        for (int i = 1; i < 3; i++) begin
            if (d_reg[i] < best_next) begin
                best_next = d_reg[i];
                nx_next   = qx_sq_reg[i];
                ny_next   = qy_sq_reg[i];
            end
        end
        if (side_reg[ST_SQ].ctr_in) begin
            best_next = '0;
            nx_next   = side_reg[ST_SQ].cx;
            ny_next   = side_reg[ST_SQ].cy;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_MIN]) begin
            best_reg <= best_next;
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
        end
        if (ld[ST_OUT]) begin
            ovl_reg <= best_reg < mag_t'(side_reg[ST_MIN].r2);
            ins_reg <= side_reg[ST_MIN].ctr_in;
            ox_reg  <= nx_reg;
            oy_reg  <= ny_reg;
        end
    end

    assign m_overlaps      = ovl_reg;
    assign m_center_inside = ins_reg;
    assign m_nearest_x     = ox_reg;
    assign m_nearest_y     = oy_reg;

endmodule

`default_nettype wire

// ===== rtl/ctot_edge.sv =====
// One triangle edge: inside-test sign, clamped projection and edge point.
`default_nettype none

module ctot_edge import ctot_pkg::*; (
    input  wire            aclk,
    input  wire stage_en_t ld,
    input  wire coord_t    ax,
    input  wire coord_t    ay,
    input  wire coord_t    bx,
    input  wire coord_t    by,
    input  wire coord_t    cx,
    input  wire coord_t    cy,
    output logic           neg_out,
    output coord_t         qx_out,
    output coord_t         qy_out
);

    edge_carry_t cr_reg [ST_DIFF:ST_TMUL];
    diff_t       px_reg, py_reg;
    dot_t        num_reg;
    mag_t        den_reg;
    logic        neg_reg;
    div_t        dv_reg [ST_DSET:ST_TMUL-1];
    pxw_t        prx_reg, pry_reg;
    coord_t      qx_reg, qy_reg;

    prod_t num_a, num_b, den_a, den_b, cr_a, cr_b;
    dot_t  num_next, den_next, crs_next;
    div_t  dv_next;
    logic [TB:0] t_val;
    pxw_t  sumx, sumy;

    always_comb begin
        num_a    = cr_reg[ST_DIFF].ex * px_reg;
        num_b    = cr_reg[ST_DIFF].ey * py_reg;
        den_a    = cr_reg[ST_DIFF].ex * cr_reg[ST_DIFF].ex;
        den_b    = cr_reg[ST_DIFF].ey * cr_reg[ST_DIFF].ey;
        cr_a     = py_reg * cr_reg[ST_DIFF].ex;
        cr_b     = px_reg * cr_reg[ST_DIFF].ey;
        num_next = dot_t'(num_a) + dot_t'(num_b);
        den_next = dot_t'(den_a) + dot_t'(den_b);
        crs_next = dot_t'(cr_a) - dot_t'(cr_b);
    end

    always_comb begin
        dv_next.zero = (den_reg == '0) || (num_reg <= 0);
        dv_next.full = (mag_t'(num_reg) >= den_reg);
        dv_next.den  = den_reg;
        dv_next.rem  = mag_t'(num_reg);
        dv_next.q    = '0;
    end

    always_comb begin
        if (dv_reg[ST_TMUL-1].zero) begin
            t_val = '0;
        end else if (dv_reg[ST_TMUL-1].full) begin
            t_val = (TB+1)'(1) << TB;
        end else begin
            t_val = {1'b0, dv_reg[ST_TMUL-1].q};
        end
        sumx = pxw_t'(cr_reg[ST_TMUL].ax) + (prx_reg >>> TB);
        sumy = pxw_t'(cr_reg[ST_TMUL].ay) + (pry_reg >>> TB);
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_DIFF]) begin
            cr_reg[ST_DIFF].ex <= diff_t'(bx) - diff_t'(ax);
            cr_reg[ST_DIFF].ey <= diff_t'(by) - diff_t'(ay);
            cr_reg[ST_DIFF].ax <= ax;
            cr_reg[ST_DIFF].ay <= ay;
            px_reg             <= diff_t'(cx) - diff_t'(ax);
            py_reg             <= diff_t'(cy) - diff_t'(ay);
        end
        if (ld[ST_DOT]) begin
            num_reg <= num_next;
            den_reg <= mag_t'(den_next);
            neg_reg <= crs_next[DW-1];
        end
        if (ld[ST_DSET]) begin
            dv_reg[ST_DSET] <= dv_next;
        end
        if (ld[ST_TMUL]) begin
            prx_reg <= pxw_t'(cr_reg[ST_TMUL-1].ex) * pxw_t'($signed({1'b0, t_val}));
            pry_reg <= pxw_t'(cr_reg[ST_TMUL-1].ey) * pxw_t'($signed({1'b0, t_val}));
        end
        if (ld[ST_PT]) begin
            qx_reg <= sumx[CW-1:0];
            qy_reg <= sumy[CW-1:0];
        end
    end

    for (genvar k = ST_DOT; k <= ST_TMUL; k++) begin : g_carry
        always_ff @(posedge aclk) begin
            if (ld[k]) begin
                cr_reg[k] <= cr_reg[k-1];
            end
        end
    end

    for (genvar k = ST_DIV0; k < ST_TMUL; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (ld[k]) begin
                dv_reg[k] <= div_step(dv_reg[k-1]);
            end
        end
    end

    assign neg_out = neg_reg;
    assign qx_out  = qx_reg;
    assign qy_out  = qy_reg;

endmodule

`default_nettype wire

// ===== rtl/ctot_checker.sv =====
// Port-level checks of the overlap test, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ctot_checker import ctot_pkg::*; (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_ready,
    input wire         m_valid,
    input wire         m_ready,
    input wire         m_overlaps,
    input wire         m_center_inside,
    input wire coord_t m_nearest_x,
    input wire coord_t m_nearest_y
);

    `CTOT_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "output valid after reset")

    `CTOT_ASSERT(a_stall_cause, aclk, aresetn, !s_ready |-> (m_valid && !m_ready), "input stalled without output backpressure")

    `CTOT_ASSERT(a_valid_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "output word dropped")

    `CTOT_ASSERT(a_word_hold, aclk, aresetn, (m_valid && !m_ready) |=> ($stable(m_nearest_x) && $stable(m_nearest_y) && $stable(m_overlaps) && $stable(m_center_inside)), "stalled output word changed")

endmodule

bind circle_triangle_overlap_test ctot_checker u_ctot_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_overlaps      (m_overlaps),
    .m_center_inside (m_center_inside),
    .m_nearest_x     (m_nearest_x),
    .m_nearest_y     (m_nearest_y)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the circle/triangle overlap test block.
`default_nettype none

module testbench import ctot_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        coord_t  cx, cy;
        radius_t r;
        coord_t  vx [3];
        coord_t  vy [3];
        bit      drain;
    } shape_t;

    typedef struct {
        logic   overlaps;
        logic   ctr_in;
        coord_t nx, ny;
    } hit_t;

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    coord_t  s_center_x = '0, s_center_y = '0;
    radius_t s_circle_radius = '0;
    coord_t  s_vert0_x = '0, s_vert0_y = '0, s_vert1_x = '0, s_vert1_y = '0;
    coord_t  s_vert2_x = '0, s_vert2_y = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    logic    m_overlaps, m_center_inside;
    coord_t  m_nearest_x, m_nearest_y;

    shape_t  pending [$];
    hit_t    expected_hits [$];
    shape_t  cur;
    int      errors = 0;
    int      words_in = 0, words_out = 0, n_overlap = 0, n_inside = 0;
    int      burst_left = 0, gap_left = 0, stall_mode = 0;
    longint  cycles = 0;

    circle_triangle_overlap_test u_dut (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_center_x, .s_center_y, .s_circle_radius,
        .s_vert0_x, .s_vert0_y, .s_vert1_x, .s_vert1_y, .s_vert2_x, .s_vert2_y,
        .m_valid, .m_ready, .m_overlaps, .m_center_inside, .m_nearest_x, .m_nearest_y
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic longint dot(longint ax, longint ay, longint bx, longint by);
        return ax * bx + ay * by;
    endfunction

    function automatic hit_t predict_hit(shape_t s);
        hit_t   h;
        longint cx, cy, ax, ay, ex, ey, num, den, t, qx, qy, d, best;
        longint unsigned rem, q;
        int     j;
        cx = s.cx;
        cy = s.cy;
        best = 0;
        h.ctr_in = 1'b1;
        h.nx = s.cx;
        h.ny = s.cy;
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            ex = longint'(s.vx[j]) - s.vx[i];
            ey = longint'(s.vy[j]) - s.vy[i];
            if (dot(cx - s.vx[i], cy - s.vy[i], -ey, ex) < 0)
                h.ctr_in = 1'b0;
        end
        if (!h.ctr_in) begin
            for (int i = 0; i < 3; i++) begin
                j = (i + 1) % 3;
                ax = s.vx[i];
                ay = s.vy[i];
                ex = longint'(s.vx[j]) - ax;
                ey = longint'(s.vy[j]) - ay;
                num = dot(cx - ax, cy - ay, ex, ey);
                den = dot(ex, ey, ex, ey);
                if (den <= 0 || num <= 0) begin
                    t = 0;
                end else if (num >= den) begin
                    t = 64'd1 << TB;
                end else begin
                    rem = num;
                    q = 0;
                    for (int k = 0; k < TB; k++) begin
                        rem = rem << 1;
                        q = q << 1;
                        if (rem >= longint'(den)) begin
                            rem = rem - den;
                            q = q | 1;
                        end
                    end
                    t = q;
                end
                qx = ax + ((ex * t) >>> TB);
                qy = ay + ((ey * t) >>> TB);
                d = dot(qx - cx, qy - cy, qx - cx, qy - cy);
                if (i == 0 || d < best) begin
                    best = d;
                    h.nx = coord_t'(qx);
                    h.ny = coord_t'(qy);
                end
            end
        end
        h.overlaps = best < longint'(s.r) * longint'(s.r);
        return h;
    endfunction

    function automatic shape_t mk(longint cx, longint cy, longint r,
                                  longint x0, longint y0, longint x1, longint y1,
                                  longint x2, longint y2);
        shape_t s;
        s.cx = coord_t'(cx);
        s.cy = coord_t'(cy);
        s.r = radius_t'(r);
        s.vx[0] = coord_t'(x0); s.vy[0] = coord_t'(y0);
        s.vx[1] = coord_t'(x1); s.vy[1] = coord_t'(y1);
        s.vx[2] = coord_t'(x2); s.vy[2] = coord_t'(y2);
        s.drain = 1'b0;
        return s;
    endfunction

    // near-center triangle, usually counter-clockwise
    function automatic shape_t rand_local();
        shape_t s;
        longint bx, by, span, cr, tmp;
        longint px [3];
        longint py [3];
        span = ($urandom_range(0, 3) == 0) ? 4000000 : 3000;
        bx = $signed($urandom_range(0, 16000000)) - 8000000;
        by = $signed($urandom_range(0, 16000000)) - 8000000;
        for (int i = 0; i < 3; i++) begin
            px[i] = bx + $signed($urandom_range(0, 2 * span)) - span;
            py[i] = by + $signed($urandom_range(0, 2 * span)) - span;
        end
        if ($urandom_range(0, 7) != 0) begin
            cr = (px[1] - px[0]) * (py[2] - py[0]) - (py[1] - py[0]) * (px[2] - px[0]);
            if (cr < 0) begin
                tmp = px[1];
                px[1] = px[2];
                px[2] = tmp;
                tmp = py[1];
                py[1] = py[2];
                py[2] = tmp;
            end
        end
        s = mk(bx + $signed($urandom_range(0, 3 * span)) - 3 * span / 2,
               by + $signed($urandom_range(0, 3 * span)) - 3 * span / 2,
               $urandom_range(0, 2 * span), px[0], py[0], px[1], py[1], px[2], py[2]);
        return s;
    endfunction

    function automatic shape_t rand_wild();
        return mk($signed($urandom), $signed($urandom), $urandom,
                  $signed($urandom), $signed($urandom), $signed($urandom),
                  $signed($urandom), $signed($urandom), $signed($urandom));
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_hits.push_back(predict_hit(cur));
                words_in++;
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending.size() == 0 ||
                             (pending[0].drain && expected_hits.size() > 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    cur = pending.pop_front();
                    s_valid <= 1'b1;
                    s_center_x <= cur.cx;
                    s_center_y <= cur.cy;
                    s_circle_radius <= cur.r;
                    s_vert0_x <= cur.vx[0];
                    s_vert0_y <= cur.vy[0];
                    s_vert1_x <= cur.vx[1];
                    s_vert1_y <= cur.vy[1];
                    s_vert2_x <= cur.vx[2];
                    s_vert2_y <= cur.vy[2];
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        cycles++;
        if (cycles % 97 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
        if (aresetn && m_valid && m_ready) begin
            hit_t e;
            if (expected_hits.size() == 0) begin
                $error("unexpected word: overlaps=%0d inside=%0d", m_overlaps,
                       m_center_inside);
                errors++;
            end else begin
                e = expected_hits.pop_front();
                words_out++;
                n_overlap += e.overlaps;
                n_inside += e.ctr_in;
                if (m_overlaps !== e.overlaps) begin
                    $error("overlaps: expected %0d, got %0d", e.overlaps, m_overlaps);
                    errors++;
                end
                if (m_center_inside !== e.ctr_in) begin
                    $error("center_inside: expected %0d, got %0d", e.ctr_in,
                           m_center_inside);
                    errors++;
                end
                if (m_nearest_x !== e.nx) begin
                    $error("nearest_x: expected %0d, got %0d", e.nx, m_nearest_x);
                    errors++;
                end
                if (m_nearest_y !== e.ny) begin
                    $error("nearest_y: expected %0d, got %0d", e.ny, m_nearest_y);
                    errors++;
                end
            end
        end
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    localparam longint MX = 8388607;
    localparam longint MN = -8388608;

    initial begin
        shape_t s;
        // inside, on a vertex, zero radius, beyond/before an edge
        pending.push_back(mk(100, 100, 50, 0, 0, 1000, 0, 0, 1000));
        pending.push_back(mk(0, 0, 0, 0, 0, 1000, 0, 0, 1000));
        pending.push_back(mk(500, -300, 300, 0, 0, 1000, 0, 0, 1000));
        pending.push_back(mk(500, -300, 301, 0, 0, 1000, 0, 0, 1000));
        pending.push_back(mk(2000, -10, 5000, 0, 0, 1000, 0, 0, 1000));
        pending.push_back(mk(-50, -50, 100, 0, 0, 1000, 0, 0, 1000));
        // clockwise, degenerate and full-range shapes
        pending.push_back(mk(100, 100, 10, 0, 0, 0, 1000, 1000, 0));
        pending.push_back(mk(3000, 7, 200, 5, 5, 5, 5, 5, 5));
        pending.push_back(mk(-40, 900, 77, 0, 0, 500, 500, 1000, 1000));
        pending.push_back(mk(MX, MX, 8388607, MN, MN, MX, MN, MN, MX));
        pending.push_back(mk(MN, MN, 8388607, MX, MX, MN, MX, MX, MN));
        pending.push_back(mk(MX, MN, 0, MN, MN, MN, MX, MN, MN));
        pending.push_back(mk(MN, MX, 8388607, MX, MN, MX, MX, MN, MN));
        pending.push_back(mk(0, 0, 8388607, MN, MN, MX, MN, MX, MX));
        pending.push_back(mk(-1, -1, 1, MX, MX, MX, MX, MN, MN));
        for (int i = 0; i < 1500; i++) begin
            s = ($urandom_range(0, 4) == 0) ? rand_wild() : rand_local();
            s.drain = (i == 400 || i == 1000);
            pending.push_back(s);
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (!(pending.size() == 0 && !s_valid && expected_hits.size() == 0))
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("checked %0d words (%0d sent): %0d overlapping, %0d center inside",
                 words_out, words_in, n_overlap, n_inside);
        $display("with random sender gaps, receiver stalls and two full drains");
        if (errors == 0 && expected_hits.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

`default_nettype wire
